### rtl/mifc_pkg.sv
package mifc_pkg;

    // Sample and filter widths
    localparam int ACC_WIDTH       = 16;
    localparam int HP_IN_WIDTH     = ACC_WIDTH + 8;
    localparam int HP_OUT_WIDTH    = 32;
    localparam int SQ_WIDTH        = 64;
    localparam int LP_IN_WIDTH     = 40;
    localparam int LP_OUT_WIDTH    = 48;
    localparam int INTENSITY_WIDTH = 32;
    localparam int COUNT_WIDTH     = 32;
    localparam int PERIOD_WIDTH    = 16;
    localparam int POLE_WIDTH      = 30;
    localparam int COEF1_WIDTH     = 31;
    localparam int COEF2_WIDTH     = 32;

    // Fixed gains: 1/1.030216813 in Q2.30 and 2^42/2303.714081
    localparam logic [30:0] HP_IN_GAIN = 31'd1042248399;
    localparam logic [30:0] LP_IN_GAIN = 31'd1909111268;

    // Register reset values
    localparam logic [PERIOD_WIDTH-1:0]       PERIOD_RESET = 16'd130;
    localparam logic [POLE_WIDTH-1:0]         POLE_RESET   = 30'd1010754974;
    localparam logic [COEF1_WIDTH-1:0]        COEF1_RESET  = 31'd2083283562;
    localparam logic signed [COEF2_WIDTH-1:0] COEF2_RESET  = -32'sd1011406104;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_PUBLISH_PERIOD   = 2'd0;
    localparam logic [1:0] REG_HIGHPASS_POLE    = 2'd1;
    localparam logic [1:0] REG_LOWPASS_COEF_ONE = 2'd2;
    localparam logic [1:0] REG_LOWPASS_COEF_TWO = 2'd3;

    typedef struct packed {
        logic signed [ACC_WIDTH-1:0] accel_x;
        logic signed [ACC_WIDTH-1:0] accel_y;
        logic signed [ACC_WIDTH-1:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic signed [INTENSITY_WIDTH-1:0] intensity;
        logic                              publish;
        logic [COUNT_WIDTH-1:0]            publish_count;
    } result_t;

    // Step strobes for one high-pass lane
    typedef struct packed {
        logic load;
        logic mul;
        logic upd;
        logic sq;
    } lane_ctrl_t;

    // Step strobes for the merging low-pass stage
    typedef struct packed {
        logic sum;
        logic mul;
        logic add;
        logic upd;
    } merge_ctrl_t;

endpackage

### rtl/mifc_hp_lane.sv
module mifc_hp_lane (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mifc_pkg::lane_ctrl_t                 ctrl,
    input  logic signed [mifc_pkg::ACC_WIDTH-1:0] accel,
    input  logic [mifc_pkg::POLE_WIDTH-1:0]      pole,
    output logic [mifc_pkg::SQ_WIDTH-1:0]        sq
);

    localparam int PROD_W = mifc_pkg::ACC_WIDTH + 32;
    localparam int HIN_W  = mifc_pkg::HP_IN_WIDTH;
    localparam logic signed [PROD_W:0] IN_HALF = (PROD_W + 1)'(1) <<< 21;
    localparam logic signed [63:0]     FB_HALF = 64'sd536870912;

    logic signed [mifc_pkg::ACC_WIDTH-1:0] accel_reg;
    logic signed [PROD_W-1:0]              in_prod_reg;
    logic signed [PROD_W-1:0]              in_prod_next;
    logic signed [62:0]                    fb_prod_reg;
    logic signed [62:0]                    fb_prod_next;
    logic signed [HIN_W-1:0]               prev_in_reg;
    logic signed [31:0]                    prev_out_reg;
    logic [63:0]                           sq_reg;
    logic [63:0]                           sq_next;

    logic signed [31:0]     gain_s;
    logic signed [30:0]     pole_s;
    logic signed [PROD_W:0] in_sum;
    logic signed [HIN_W-1:0] x_next;
    logic signed [63:0]     fb_sum;
    logic signed [33:0]     fb_rnd;
    logic signed [34:0]     y_sum;
    logic signed [31:0]     y_next;
    logic [31:0]            mag;

    // Both products of the lane, one multiplier each
    assign gain_s       = $signed({1'b0, mifc_pkg::HP_IN_GAIN});
    assign pole_s       = $signed({1'b0, pole});
    assign in_prod_next = accel_reg * gain_s;
    assign fb_prod_next = pole_s * prev_out_reg;

    // Rounded scaled input and rounded feedback, then saturate the new output
    assign in_sum = (PROD_W + 1)'(in_prod_reg) + IN_HALF;
    assign x_next = $signed(in_sum[HIN_W+21:22]);
    assign fb_sum = 64'(fb_prod_reg) + FB_HALF;
    assign fb_rnd = $signed(fb_sum[63:30]);
    assign y_sum  = 35'(x_next) - 35'(prev_in_reg) + 35'(fb_rnd);

    always_comb
    begin
        if (y_sum[34:31] == {4{y_sum[34]}})
        begin
            y_next = y_sum[31:0];
        end
        else if (y_sum[34])
        begin
            y_next = 32'sh8000_0000;
        end
        else
        begin
            y_next = 32'sh7FFF_FFFF;
        end
    end

    // Square of the magnitude; the most negative value maps to 2^31
    assign mag     = prev_out_reg[31] ? (~prev_out_reg + 32'd1) : prev_out_reg;
    assign sq_next = mag * mag;

    // Filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_in_reg  <= '0;
            prev_out_reg <= '0;
        end
        else if (ctrl.upd)
        begin
            prev_in_reg  <= x_next;
            prev_out_reg <= y_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            accel_reg <= accel;
        end
        if (ctrl.mul)
        begin
            in_prod_reg <= in_prod_next;
            fb_prod_reg <= fb_prod_next;
        end
        if (ctrl.sq)
        begin
            sq_reg <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule

### rtl/mifc_lowpass_merge.sv
module mifc_lowpass_merge (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  mifc_pkg::merge_ctrl_t                        ctrl,
    input  logic [2:0][mifc_pkg::SQ_WIDTH-1:0]           sq,
    input  logic [mifc_pkg::COEF1_WIDTH-1:0]             coef_one,
    input  logic signed [mifc_pkg::COEF2_WIDTH-1:0]      coef_two,
    output logic signed [mifc_pkg::INTENSITY_WIDTH-1:0]  intensity
);

    localparam int LIN_W  = mifc_pkg::LP_IN_WIDTH;
    localparam int LOUT_W = mifc_pkg::LP_OUT_WIDTH;
    localparam logic [63:0]        LOW_HALF = 64'h0000_0800_0000_0000;
    localparam logic signed [57:0] FB_HALF  = 58'sd536870912;
    localparam logic signed [48:0] OUT_HALF = 49'sd4096;

    logic [63:0]              sum_reg;
    logic [63:0]              sum_next;
    logic [62:0]              hprod_reg;
    logic [62:0]              hprod_next;
    logic [62:0]              lprod_reg;
    logic [62:0]              lprod_next;
    logic signed [56:0]       hc1_reg;
    logic signed [56:0]       hc1_next;
    logic signed [56:0]       hc2_reg;
    logic signed [56:0]       hc2_next;
    logic signed [56:0]       lc1_reg;
    logic signed [56:0]       lc1_next;
    logic signed [56:0]       lc2_reg;
    logic signed [56:0]       lc2_next;
    logic [LIN_W-1:0]         xin_reg;
    logic [LIN_W-1:0]         xin_next;
    logic signed [57:0]       hsum_reg;
    logic signed [57:0]       hsum_next;
    logic signed [57:0]       lsum_reg;
    logic signed [57:0]       lsum_next;
    logic [LIN_W-1:0]         lp_in0_reg;
    logic [LIN_W-1:0]         lp_in1_reg;
    logic signed [LOUT_W-1:0] lp_out0_reg;
    logic signed [LOUT_W-1:0] lp_out1_reg;
    logic signed [LOUT_W-1:0] wn_next;

    logic signed [31:0] c1_s;
    logic signed [23:0] h0;
    logic signed [23:0] h1;
    logic signed [24:0] l0;
    logic signed [24:0] l1;
    logic [63:0]        lowprod;
    logic [63:0]        bsum;
    logic [51:0]        u;
    logic signed [33:0] lsum_sh;
    logic signed [58:0] fb_sum;
    logic signed [52:0] fb;
    logic signed [54:0] wn_sum;
    logic signed [48:0] out_rnd;
    logic signed [35:0] out_q;

    // Merge the three lanes
    assign sum_next = sq[0] + sq[1] + sq[2];

    // Input gain split in two 32-bit halves; feedback split into high and low parts
    assign hprod_next = sum_reg[63:32] * mifc_pkg::LP_IN_GAIN;
    assign lprod_next = sum_reg[31:0] * mifc_pkg::LP_IN_GAIN;
    assign c1_s       = $signed({1'b0, coef_one});
    assign h0         = lp_out0_reg[47:24];
    assign h1         = lp_out1_reg[47:24];
    assign l0         = $signed({1'b0, lp_out0_reg[23:0]});
    assign l1         = $signed({1'b0, lp_out1_reg[23:0]});
    assign hc1_next   = c1_s * h1;
    assign hc2_next   = coef_two * h0;
    assign lc1_next   = c1_s * l1;
    assign lc2_next   = coef_two * l0;

    // Recombine the input product with rounding and clamp it; add up the feedback halves
    assign lowprod   = {1'b0, lprod_reg} + LOW_HALF;
    assign bsum      = {1'b0, hprod_reg} + {32'd0, lowprod[63:32]};
    assign u         = bsum[63:12];
    assign xin_next  = (|u[51:39]) ? {1'b0, {(LIN_W - 1){1'b1}}} : u[LIN_W-1:0];
    assign hsum_next = 58'(hc1_reg) + 58'(hc2_reg);
    assign lsum_next = 58'(lc1_reg) + 58'(lc2_reg) + FB_HALF;

    // New low-pass output
    assign lsum_sh = lsum_reg[57:24];
    assign fb_sum  = 59'(hsum_reg) + 59'(lsum_sh);
    assign fb      = fb_sum[58:6];
    assign wn_sum  = $signed({15'd0, lp_in0_reg}) + $signed({14'd0, lp_in1_reg, 1'b0})
                   + $signed({15'd0, xin_reg}) + 55'(fb);

    always_comb
    begin
        if (wn_sum[54:47] == {8{wn_sum[54]}})
        begin
            wn_next = wn_sum[47:0];
        end
        else if (wn_sum[54])
        begin
            wn_next = {1'b1, {(LOUT_W - 1){1'b0}}};
        end
        else
        begin
            wn_next = {1'b0, {(LOUT_W - 1){1'b1}}};
        end
    end

    // Intensity is the output doubled in Q18.14: round by 2^13 and saturate
    assign out_rnd = 49'(lp_out1_reg) + OUT_HALF;
    assign out_q   = out_rnd[48:13];

    always_comb
    begin
        if (out_q[35:31] == {5{out_q[35]}})
        begin
            intensity = out_q[31:0];
        end
        else if (out_q[35])
        begin
            intensity = 32'sh8000_0000;
        end
        else
        begin
            intensity = 32'sh7FFF_FFFF;
        end
    end

    // Filter history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_in0_reg  <= '0;
            lp_in1_reg  <= '0;
            lp_out0_reg <= '0;
            lp_out1_reg <= '0;
        end
        else if (ctrl.upd)
        begin
            lp_in0_reg  <= lp_in1_reg;
            lp_in1_reg  <= xin_reg;
            lp_out0_reg <= lp_out1_reg;
            lp_out1_reg <= wn_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.sum)
        begin
            sum_reg <= sum_next;
        end
        if (ctrl.mul)
        begin
            hprod_reg <= hprod_next;
            lprod_reg <= lprod_next;
            hc1_reg   <= hc1_next;
            hc2_reg   <= hc2_next;
            lc1_reg   <= lc1_next;
            lc2_reg   <= lc2_next;
        end
        if (ctrl.add)
        begin
            xin_reg  <= xin_next;
            hsum_reg <= hsum_next;
            lsum_reg <= lsum_next;
        end
    end

endmodule

### rtl/motion_intensity_filter_chain.sv
// Channel  | Direction | Handshake                      | Payload
// sample   | in        | sample_valid / sample_stall    | mifc_pkg::sample_t
// result   | out       | result_valid / result_stall    | mifc_pkg::result_t
// config   | in        | psel / penable / pwrite, pready | paddr, pwdata, prdata
//
// One sample is in flight at a time. A transaction takes eight sequencer steps
// (lane products, high-pass update, square, merge, low-pass products, two adds, result load)
// and the result register loads in the final step; the next sample can be taken in the
// cycle after that load, so a new sample waits until the last one is through.
// A held result stalls only the final load; reset clears filter history and counters.
module motion_intensity_filter_chain (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  mifc_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_stall,
    output mifc_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_HP    = 4'd2;
    localparam logic [3:0] ST_SQ    = 4'd3;
    localparam logic [3:0] ST_SUM   = 4'd4;
    localparam logic [3:0] ST_LPMUL = 4'd5;
    localparam logic [3:0] ST_LPADD = 4'd6;
    localparam logic [3:0] ST_LPOUT = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic [mifc_pkg::PERIOD_WIDTH-1:0]       period_reg;
    logic [mifc_pkg::POLE_WIDTH-1:0]         pole_reg;
    logic [mifc_pkg::COEF1_WIDTH-1:0]        coef_one_reg;
    logic signed [mifc_pkg::COEF2_WIDTH-1:0] coef_two_reg;

    logic [mifc_pkg::PERIOD_WIDTH-1:0] sample_count_reg;
    logic [mifc_pkg::PERIOD_WIDTH-1:0] sample_count_next;
    logic [mifc_pkg::COUNT_WIDTH-1:0]  publish_total_reg;
    logic [mifc_pkg::COUNT_WIDTH-1:0]  publish_total_next;
    logic                              result_valid_reg;
    mifc_pkg::result_t                 result_reg;
    mifc_pkg::result_t                 result_next;

    logic                                    cfg_write;
    logic                                    accept;
    logic                                    deliver;
    logic                                    publish_now;
    mifc_pkg::lane_ctrl_t                    lane_ctrl;
    mifc_pkg::merge_ctrl_t                   merge_ctrl;
    logic [2:0][mifc_pkg::ACC_WIDTH-1:0]     lane_accel;
    logic [2:0][mifc_pkg::SQ_WIDTH-1:0]      lane_sq;
    logic signed [mifc_pkg::INTENSITY_WIDTH-1:0] intensity;

    // Configuration port
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= mifc_pkg::PERIOD_RESET;
            pole_reg     <= mifc_pkg::POLE_RESET;
            coef_one_reg <= mifc_pkg::COEF1_RESET;
            coef_two_reg <= mifc_pkg::COEF2_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                mifc_pkg::REG_PUBLISH_PERIOD:   period_reg   <= pwdata[15:0];
                mifc_pkg::REG_HIGHPASS_POLE:    pole_reg     <= pwdata[29:0];
                mifc_pkg::REG_LOWPASS_COEF_ONE: coef_one_reg <= pwdata[30:0];
                mifc_pkg::REG_LOWPASS_COEF_TWO: coef_two_reg <= $signed(pwdata);
                default:                        period_reg   <= period_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            mifc_pkg::REG_PUBLISH_PERIOD:   prdata = {16'd0, period_reg};
            mifc_pkg::REG_HIGHPASS_POLE:    prdata = {2'd0, pole_reg};
            mifc_pkg::REG_LOWPASS_COEF_ONE: prdata = {1'b0, coef_one_reg};
            mifc_pkg::REG_LOWPASS_COEF_TWO: prdata = coef_two_reg;
            default:                        prdata = '0;
        endcase
    end

    // Sequencer
    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != ST_IDLE);
    assign deliver      = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                state_next = sample_valid ? ST_MUL : ST_IDLE;
            end
            ST_MUL, ST_HP, ST_SQ, ST_SUM, ST_LPMUL, ST_LPADD, ST_LPOUT:
            begin
                state_next = state_reg + 4'd1;
            end
            ST_DONE:
            begin
                state_next = deliver ? ST_IDLE : ST_DONE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Step strobes
    assign lane_ctrl.load  = accept;
    assign lane_ctrl.mul   = (state_reg == ST_MUL);
    assign lane_ctrl.upd   = (state_reg == ST_HP);
    assign lane_ctrl.sq    = (state_reg == ST_SQ);
    assign merge_ctrl.sum  = (state_reg == ST_SUM);
    assign merge_ctrl.mul  = (state_reg == ST_LPMUL);
    assign merge_ctrl.add  = (state_reg == ST_LPADD);
    assign merge_ctrl.upd  = (state_reg == ST_LPOUT);

    // One high-pass lane per axis
    assign lane_accel[0] = sample.accel_x;
    assign lane_accel[1] = sample.accel_y;
    assign lane_accel[2] = sample.accel_z;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        mifc_hp_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl),
            .accel ($signed(lane_accel[i])),
            .pole  (pole_reg),
            .sq    (lane_sq[i])
        );
    end

    mifc_lowpass_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (merge_ctrl),
        .sq        (lane_sq),
        .coef_one  (coef_one_reg),
        .coef_two  (coef_two_reg),
        .intensity (intensity)
    );

    // Publish counter and result register
    assign publish_now        = (sample_count_reg >= period_reg);
    assign sample_count_next  = publish_now ? '0 : sample_count_reg + 16'd1;
    assign publish_total_next = publish_now ? publish_total_reg + 32'd1 : publish_total_reg;

    always_comb
    begin
        result_next.intensity     = intensity;
        result_next.publish       = publish_now;
        result_next.publish_count = publish_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg  <= '0;
            publish_total_reg <= '0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (deliver)
            begin
                sample_count_reg  <= sample_count_next;
                publish_total_reg <= publish_total_next;
                result_valid_reg  <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (deliver)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // An accepted transaction starts the lane products on the next cycle.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_MUL))
        else $error("accepted sample did not start the sequencer");

    // A new result appears only out of the final step.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared outside the final step");

    // Working steps advance one per cycle without waiting.
    a_steps_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_reg != ST_DONE)
        |=> (state_reg == $past(state_reg) + 4'd1))
        else $error("sequencer skipped or stalled a working step");

    // A pending publish result means the sample counter has just been cleared.
    a_publish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.publish) |-> (sample_count_reg == '0))
        else $error("publish reported without clearing the sample count");
`endif

endmodule

### tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;
    localparam wide_t ONE = 1;
    localparam wide_t LP_IN_LIMIT = (ONE << 39) - 1;

    // Corner samples for the directed part: x is the top field.
    localparam logic [47:0] EDGE_SAMPLES [10] = '{
        48'h0000_0000_0000, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000,
        48'h7FFF_8000_0000, 48'hFFFF_0001_FFFF, 48'h5555_AAAA_5555,
        48'hAAAA_5555_AAAA, 48'h0000_0000_04E2, 48'h8000_7FFF_8000,
        48'h0000_0000_0000
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              sample_valid;
    logic              sample_stall;
    mifc_pkg::sample_t sample;
    logic              result_valid;
    logic              result_stall = 1'b0;
    mifc_pkg::result_t result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;

    // Mirror of the register file.
    logic [mifc_pkg::PERIOD_WIDTH-1:0]       period_setting   = mifc_pkg::PERIOD_RESET;
    logic [mifc_pkg::POLE_WIDTH-1:0]         pole_setting     = mifc_pkg::POLE_RESET;
    logic [mifc_pkg::COEF1_WIDTH-1:0]        gain_one_setting = mifc_pkg::COEF1_RESET;
    logic signed [mifc_pkg::COEF2_WIDTH-1:0] gain_two_setting = mifc_pkg::COEF2_RESET;

    // Mirror of the filter history and the publish counters.
    logic signed [mifc_pkg::HP_IN_WIDTH-1:0]  hp_last_in  [3] = '{default: '0};
    logic signed [mifc_pkg::HP_OUT_WIDTH-1:0] hp_last_out [3] = '{default: '0};
    logic signed [mifc_pkg::LP_IN_WIDTH-1:0]  lp_hist_in  [2] = '{default: '0};
    logic signed [mifc_pkg::LP_OUT_WIDTH-1:0] lp_hist_out [2] = '{default: '0};
    logic [mifc_pkg::PERIOD_WIDTH-1:0]        samples_since_publish = '0;
    logic [mifc_pkg::COUNT_WIDTH-1:0]         publish_events = '0;

    mifc_pkg::result_t pending_results[$];

    motion_intensity_filter_chain dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 clk = ~clk;

    // The result side stalls at random at the rate that stall_pct sets.
    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    // Saturate a value to a signed field of the given width.
    function automatic wide_t clamp(input wide_t v, input int w);
        wide_t hi;
        hi = (ONE << (w - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Advance the filter mirror by one sample and return the expected result.
    function automatic mifc_pkg::result_t filter_sample(input mifc_pkg::sample_t s);
        wide_t             axis [3];
        wide_t             x;
        wide_t             y;
        wide_t             sq_sum;
        wide_t             u;
        wide_t             fb;
        wide_t             wn;
        wide_t             inten;
        mifc_pkg::result_t r;
        int                i;
        axis[0] = wide_t'($signed(s.accel_x));
        axis[1] = wide_t'($signed(s.accel_y));
        axis[2] = wide_t'($signed(s.accel_z));
        sq_sum = 0;

        // Per-axis high-pass with rounded input scaling and feedback.
        for (i = 0; i < 3; i++)
        begin
            x = (axis[i] * wide_t'(mifc_pkg::HP_IN_GAIN) + (ONE << 21)) >>> 22;
            y = (x - wide_t'(hp_last_in[i]))
                + ((wide_t'(pole_setting) * wide_t'(hp_last_out[i]) + (ONE << 29)) >>> 30);
            y = clamp(y, mifc_pkg::HP_OUT_WIDTH);
            hp_last_in[i] = x[mifc_pkg::HP_IN_WIDTH-1:0];
            hp_last_out[i] = y[mifc_pkg::HP_OUT_WIDTH-1:0];
            sq_sum = sq_sum + y * y;
        end

        // Second-order low-pass on the scaled sum of squares.
        u = (sq_sum * wide_t'(mifc_pkg::LP_IN_GAIN) + (ONE << 43)) >>> 44;
        if (u > LP_IN_LIMIT)
            u = LP_IN_LIMIT;
        fb = (wide_t'(gain_one_setting) * wide_t'(lp_hist_out[1])
              + wide_t'(gain_two_setting) * wide_t'(lp_hist_out[0]) + (ONE << 29)) >>> 30;
        wn = clamp(wide_t'(lp_hist_in[0]) + 2 * wide_t'(lp_hist_in[1]) + u + fb,
                   mifc_pkg::LP_OUT_WIDTH);
        lp_hist_in[0] = lp_hist_in[1];
        lp_hist_in[1] = u[mifc_pkg::LP_IN_WIDTH-1:0];
        lp_hist_out[0] = lp_hist_out[1];
        lp_hist_out[1] = wn[mifc_pkg::LP_OUT_WIDTH-1:0];
        inten = clamp((wn + (ONE << 12)) >>> 13, mifc_pkg::INTENSITY_WIDTH);
        r.intensity = inten[mifc_pkg::INTENSITY_WIDTH-1:0];

        // Publish when the sample count has reached the period.
        if (samples_since_publish >= period_setting)
        begin
            publish_events = publish_events + 1'b1;
            samples_since_publish = '0;
            r.publish = 1'b1;
        end
        else
        begin
            samples_since_publish = samples_since_publish + 1'b1;
            r.publish = 1'b0;
        end
        r.publish_count = publish_events;
        return r;
    endfunction

    task automatic report(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    // Compare every accepted result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        mifc_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report("unexpected result, intensity", 0, result.intensity);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.intensity !== want.intensity)
                    report("intensity", want.intensity, result.intensity);
                if (result.publish !== want.publish)
                    report("publish", want.publish, result.publish);
                if (result.publish_count !== want.publish_count)
                    report("publish_count", want.publish_count, result.publish_count);
            end
        end
    end

    // Send one sample transaction; called and left at a falling edge.
    task automatic send_sample(input mifc_pkg::sample_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        pending_results.push_back(filter_sample(s));
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write one register, then read it back and check the stored value.
    task automatic program_register(input logic [1:0] index, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] stored;
        case (index)
            mifc_pkg::REG_PUBLISH_PERIOD:
                period_setting = value[mifc_pkg::PERIOD_WIDTH-1:0];
            mifc_pkg::REG_HIGHPASS_POLE:
                pole_setting = value[mifc_pkg::POLE_WIDTH-1:0];
            mifc_pkg::REG_LOWPASS_COEF_ONE:
                gain_one_setting = value[mifc_pkg::COEF1_WIDTH-1:0];
            default:
                gain_two_setting = value;
        endcase
        case (index)
            mifc_pkg::REG_PUBLISH_PERIOD:   stored = 32'(period_setting);
            mifc_pkg::REG_HIGHPASS_POLE:    stored = 32'(pole_setting);
            mifc_pkg::REG_LOWPASS_COEF_ONE: stored = 32'(gain_one_setting);
            default:                        stored = gain_two_setting;
        endcase

        // Write: setup cycle, then access cycle.
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);

        // Read back the same register.
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        if (readback !== stored)
            report("register readback", stored, readback);
    endtask

    // Field extremes and bit patterns under the reset settings.
    task automatic test_sample_extremes();
        int i;
        send_idle_pct = 0;
        stall_pct = 0;
        for (i = 0; i < 10; i++)
            send_sample(mifc_pkg::sample_t'(EDGE_SAMPLES[i]));
        wait_idle();
    endtask

    // Period of zero, of one, of four, and then a period lowered to two.
    task automatic test_publish_period();
        int i;
        program_register(mifc_pkg::REG_PUBLISH_PERIOD, 32'd0);
        for (i = 0; i < 2; i++)
            send_sample(mifc_pkg::sample_t'({16'($urandom), 16'($urandom), 16'($urandom)}));
        wait_idle();
        program_register(mifc_pkg::REG_PUBLISH_PERIOD, 32'd1);
        for (i = 0; i < 3; i++)
            send_sample(mifc_pkg::sample_t'({16'($urandom), 16'($urandom), 16'($urandom)}));
        wait_idle();
        program_register(mifc_pkg::REG_PUBLISH_PERIOD, 32'd4);
        for (i = 0; i < 4; i++)
            send_sample(mifc_pkg::sample_t'({16'($urandom), 16'($urandom), 16'($urandom)}));
        wait_idle();
        program_register(mifc_pkg::REG_PUBLISH_PERIOD, 32'd2);
        for (i = 0; i < 2; i++)
            send_sample(mifc_pkg::sample_t'({16'($urandom), 16'($urandom), 16'($urandom)}));
        wait_idle();
    endtask

    // Coefficients at both ends of their ranges, with junk in unused bits.
    task automatic test_coefficient_extremes();
        int i;
        program_register(mifc_pkg::REG_PUBLISH_PERIOD, 32'hFFFF_FFFF);
        program_register(mifc_pkg::REG_HIGHPASS_POLE, 32'hC000_0000);
        program_register(mifc_pkg::REG_LOWPASS_COEF_ONE, 32'h8000_0000);
        program_register(mifc_pkg::REG_LOWPASS_COEF_TWO, 32'h8000_0000);
        for (i = 0; i < 3; i++)
            send_sample(mifc_pkg::sample_t'(EDGE_SAMPLES[i]));
        wait_idle();
        program_register(mifc_pkg::REG_HIGHPASS_POLE, 32'hFFFF_FFFF);
        program_register(mifc_pkg::REG_LOWPASS_COEF_ONE, 32'h7FFF_FFFF);
        program_register(mifc_pkg::REG_LOWPASS_COEF_TWO, 32'h0000_0000);
        for (i = 0; i < 3; i++)
            send_sample(mifc_pkg::sample_t'(EDGE_SAMPLES[i + 3]));
        wait_idle();
    endtask

    // Random samples under each idling mode and a mix of register settings.
    task automatic test_random_traffic();
        logic [15:0]       corner [4];
        mifc_pkg::sample_t s;
        logic [31:0]       mag;
        int                mode;
        int                phase;
        int                n;
        int                kind;
        corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        for (mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 62; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            for (phase = 0; phase < 2; phase++)
            begin
                wait_idle();
                case ((mode * 2 + phase) % 4)
                    // Random stable low-pass, random pole, short period.
                    0:
                    begin
                        mag = $urandom_range(32'h3FFF_FFFF, 0);
                        program_register(mifc_pkg::REG_PUBLISH_PERIOD,
                                         {16'($urandom), 16'($urandom_range(40, 0))});
                        program_register(mifc_pkg::REG_HIGHPASS_POLE, $urandom);
                        program_register(mifc_pkg::REG_LOWPASS_COEF_ONE,
                                         {1'($urandom),
                                          31'($urandom_range(32'h4000_0000 + mag - 1, 0))});
                        program_register(mifc_pkg::REG_LOWPASS_COEF_TWO, -mag);
                    end
                    // Reset coefficients with a random period.
                    1:
                    begin
                        program_register(mifc_pkg::REG_PUBLISH_PERIOD,
                                         $urandom_range(300, 1));
                        program_register(mifc_pkg::REG_HIGHPASS_POLE,
                                         32'(mifc_pkg::POLE_RESET));
                        program_register(mifc_pkg::REG_LOWPASS_COEF_ONE,
                                         32'(mifc_pkg::COEF1_RESET));
                        program_register(mifc_pkg::REG_LOWPASS_COEF_TWO,
                                         mifc_pkg::COEF2_RESET);
                    end
                    // Growing low-pass that drives the output into saturation.
                    2:
                    begin
                        program_register(mifc_pkg::REG_PUBLISH_PERIOD, 32'd0);
                        program_register(mifc_pkg::REG_HIGHPASS_POLE, 32'h3FFF_FFFF);
                        program_register(mifc_pkg::REG_LOWPASS_COEF_ONE, 32'h7FFF_FFFF);
                        program_register(mifc_pkg::REG_LOWPASS_COEF_TWO, 32'h0000_0000);
                    end
                    // Oscillating low-pass that swings to both rails.
                    default:
                    begin
                        program_register(mifc_pkg::REG_PUBLISH_PERIOD,
                                         $urandom_range(65535, 1));
                        program_register(mifc_pkg::REG_HIGHPASS_POLE, 32'd0);
                        program_register(mifc_pkg::REG_LOWPASS_COEF_ONE, 32'd0);
                        program_register(mifc_pkg::REG_LOWPASS_COEF_TWO, 32'h8000_0000);
                    end
                endcase
                for (n = 0; n < 132; n++)
                begin
                    kind = $urandom_range(9);
                    if (kind < 4)
                    begin
                        s.accel_x = 16'($urandom);
                        s.accel_y = 16'($urandom);
                        s.accel_z = 16'($urandom);
                    end
                    else if (kind < 8)
                    begin
                        // Device at rest or moving gently, gravity on z.
                        s.accel_x = 16'(int'($urandom_range(600)) - 300);
                        s.accel_y = 16'(int'($urandom_range(600)) - 300);
                        s.accel_z = 16'(int'($urandom_range(1200)) - 600
                                        + ((kind % 2 == 0) ? 1250 : -1250));
                    end
                    else
                    begin
                        s.accel_x = corner[$urandom_range(3)];
                        s.accel_y = corner[$urandom_range(3)];
                        s.accel_z = corner[$urandom_range(3)];
                    end
                    send_sample(s);
                end
            end
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_sample_extremes();
        test_publish_period();
        test_coefficient_extremes();
        test_random_traffic();

        wait_idle();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

### motion_intensity_filter_chain.f
rtl/mifc_pkg.sv
rtl/mifc_hp_lane.sv
rtl/mifc_lowpass_merge.sv
rtl/motion_intensity_filter_chain.sv
tb/tb.sv
